// File: sv/sit_pkg.sv
package sit_pkg;

   localparam int COORD_WIDTH = 16;
   localparam int DIFF_WIDTH  = COORD_WIDTH + 1;
   localparam int PROD_WIDTH  = 2 * COORD_WIDTH + 2;
   localparam int STAGES      = 4;

   typedef logic signed [COORD_WIDTH-1:0] coord_type;

   typedef enum logic [1:0] {
      KIND_NONE     = 2'd0,
      KIND_ENDPOINT = 2'd1,
      KIND_CROSSING = 2'd2
   } kind_type;

   typedef struct packed {
      coord_type ax;
      coord_type ay;
      coord_type bx;
      coord_type by;
      coord_type cx;
      coord_type cy;
      coord_type dx;
      coord_type dy;
   } req_type;

   typedef struct packed {
      logic       intersects;
      logic [1:0] contact_kind;
   } rsp_type;

   // pos/neg: sign of the cross product; on_seg: point inside the segment's box
   typedef struct packed {
      logic pos;
      logic neg;
      logic on_seg;
   } orient_type;

   // stage advance enables for the three orientation stages
   typedef struct packed {
      logic s3;
      logic s2;
      logic s1;
   } orient_en_type;

endpackage

// File: sv/sit_if.sv
interface sit_req_if;
   import sit_pkg::*;

   logic    valid;
   logic    ready;
   req_type data;

   modport source (output valid, output data, input ready);
   modport sink   (input valid, input data, output ready);

endinterface

interface sit_rsp_if;
   import sit_pkg::*;

   logic    valid;
   logic    ready;
   rsp_type data;

   modport source (output valid, output data, input ready);
   modport sink   (input valid, input data, output ready);

endinterface

// File: sv/sit_orient.sv
module sit_orient
   import sit_pkg::*;
(
   input  logic          clock,
   input  orient_en_type en,
   input  coord_type     p_x,
   input  coord_type     p_y,
   input  coord_type     q_x,
   input  coord_type     q_y,
   input  coord_type     r_x,
   input  coord_type     r_y,
   output orient_type    result
);

   logic signed [DIFF_WIDTH-1:0] ux_ff, uy_ff, vx_ff, vy_ff;
   logic signed [DIFF_WIDTH-1:0] ux_in, uy_in, vx_in, vy_in;
   logic signed [PROD_WIDTH-1:0] l_ff, r_ff, l_in, r_in;
   logic                         box1_ff, box2_ff, box_in;
   orient_type                   result_ff, result_in;
   logic                         in_x, in_y;

   always_comb begin
      ux_in = DIFF_WIDTH'(q_x) - DIFF_WIDTH'(p_x);
      uy_in = DIFF_WIDTH'(q_y) - DIFF_WIDTH'(p_y);
      vx_in = DIFF_WIDTH'(r_x) - DIFF_WIDTH'(p_x);
      vy_in = DIFF_WIDTH'(r_y) - DIFF_WIDTH'(p_y);
      in_x  = (p_x <= r_x && r_x <= q_x) || (q_x <= r_x && r_x <= p_x);
      in_y  = (p_y <= r_y && r_y <= q_y) || (q_y <= r_y && r_y <= p_y);
      box_in = in_x && in_y;
      l_in  = ux_ff * vy_ff;
      r_in  = uy_ff * vx_ff;
      result_in.pos    = l_ff > r_ff;
      result_in.neg    = l_ff < r_ff;
      result_in.on_seg = box2_ff;
   end

   always_ff @(posedge clock) begin
      if (en.s1) begin
         ux_ff   <= ux_in;
         uy_ff   <= uy_in;
         vx_ff   <= vx_in;
         vy_ff   <= vy_in;
         box1_ff <= box_in;
      end
      if (en.s2) begin
         l_ff    <= l_in;
         r_ff    <= r_in;
         box2_ff <= box1_ff;
      end
      if (en.s3) begin
         result_ff <= result_in;
      end
   end

   assign result = result_ff;

endmodule

// File: sv/segment_intersection_test_top.sv
// Channel | Direction | Payload                                  | Handshake
// req     | in        | ax, ay, bx, by, cx, cy, dx, dy (signed)  | valid/ready
// rsp     | out       | intersects, contact_kind                 | valid/ready
//
// Four-stage pipeline: differences and box tests, products, compares, result.
// One transaction per cycle unless a full pipeline is stalled by rsp.ready.
// The multiplier stage sets the clock; each stage advances when it is empty or
// the next one advances, so bubbles are squeezed out and a stall loses nothing.
// Synchronous reset clears the valid bits only.
module segment_intersection_test_top
   import sit_pkg::*;
(
   input  logic      clock,
   input  logic      reset,
   sit_req_if.sink   req,
   sit_rsp_if.source rsp
);

   logic [STAGES-1:0] valid_ff, valid_in, en;
   orient_en_type     oen;
   orient_type        s_c, s_d, s_a, s_b;
   rsp_type           rsp_ff, rsp_in;
   logic              touch, cross_ab, cross_cd;
   kind_type          kind;

   always_comb begin
      en[STAGES-1] = !valid_ff[STAGES-1] || rsp.ready;
      for (int i = STAGES - 2; i >= 0; i--) begin
         en[i] = !valid_ff[i] || en[i+1];
      end
      valid_in[0] = en[0] ? req.valid : valid_ff[0];
      for (int i = 1; i < STAGES; i++) begin
         valid_in[i] = en[i] ? valid_ff[i-1] : valid_ff[i];
      end
      oen.s1 = en[0];
      oen.s2 = en[1];
      oen.s3 = en[2];
   end

   sit_orient u_side_c (
      .clock(clock), .en(oen),
      .p_x(req.data.ax), .p_y(req.data.ay), .q_x(req.data.bx), .q_y(req.data.by),
      .r_x(req.data.cx), .r_y(req.data.cy), .result(s_c)
   );

   sit_orient u_side_d (
      .clock(clock), .en(oen),
      .p_x(req.data.ax), .p_y(req.data.ay), .q_x(req.data.bx), .q_y(req.data.by),
      .r_x(req.data.dx), .r_y(req.data.dy), .result(s_d)
   );

   sit_orient u_side_a (
      .clock(clock), .en(oen),
      .p_x(req.data.cx), .p_y(req.data.cy), .q_x(req.data.dx), .q_y(req.data.dy),
      .r_x(req.data.ax), .r_y(req.data.ay), .result(s_a)
   );

   sit_orient u_side_b (
      .clock(clock), .en(oen),
      .p_x(req.data.cx), .p_y(req.data.cy), .q_x(req.data.dx), .q_y(req.data.dy),
      .r_x(req.data.bx), .r_y(req.data.by), .result(s_b)
   );

   always_comb begin
      touch = (!s_c.pos && !s_c.neg && s_c.on_seg) ||
              (!s_d.pos && !s_d.neg && s_d.on_seg) ||
              (!s_a.pos && !s_a.neg && s_a.on_seg) ||
              (!s_b.pos && !s_b.neg && s_b.on_seg);
      cross_ab = (s_c.pos && s_d.neg) || (s_c.neg && s_d.pos);
      cross_cd = (s_a.pos && s_b.neg) || (s_a.neg && s_b.pos);
      if (touch) begin
         kind = KIND_ENDPOINT;
      end else if (cross_ab && cross_cd) begin
         kind = KIND_CROSSING;
      end else begin
         kind = KIND_NONE;
      end
      rsp_in.intersects   = kind != KIND_NONE;
      rsp_in.contact_kind = kind;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else begin
         valid_ff <= valid_in;
      end
      if (en[STAGES-1]) begin
         rsp_ff <= rsp_in;
      end
   end

   assign req.ready = en[0];
   assign rsp.valid = valid_ff[STAGES-1];
   assign rsp.data  = rsp_ff;

endmodule

// File: verif/segment_intersection_checker.sv
`timescale 1ns / 1ps

module segment_intersection_checker
   import sit_pkg::*;
(
   input  logic clock,
   input  logic reset,
   sit_req_if   req_mon,
   sit_rsp_if   rsp_mon,
   output int   fail_count,
   output int   pending,
   output int   seen_apart,
   output int   seen_touch,
   output int   seen_cross
);

   kind_type expected_kinds[$];
   int       errors = 0;
   int       n_apart = 0;
   int       n_touch = 0;
   int       n_cross = 0;

   assign fail_count = errors;
   assign pending    = expected_kinds.size();
   assign seen_apart = n_apart;
   assign seen_touch = n_touch;
   assign seen_cross = n_cross;

   function automatic longint coord_value(input coord_type c);
      return longint'(c);
   endfunction

   // +1 left, -1 right, 0 collinear: sign of (q - p) x (r - p)
   function automatic int orientation(input longint px, input longint py,
                                      input longint qx, input longint qy,
                                      input longint rx, input longint ry);
      longint lhs;
      longint rhs;
      lhs = (qx - px) * (ry - py);
      rhs = (qy - py) * (rx - px);
      if (lhs > rhs) return 1;
      if (lhs < rhs) return -1;
      return 0;
   endfunction

   function automatic bit in_span(input longint a, input longint b, input longint v);
      longint lo;
      longint hi;
      lo = (a < b) ? a : b;
      hi = (a < b) ? b : a;
      return (v >= lo) && (v <= hi);
   endfunction

   function automatic kind_type classify(input req_type r);
      longint ax, ay, bx, by, cx, cy, dx, dy;
      int     s_c, s_d, s_a, s_b;
      bit     touch;
      ax = coord_value(r.ax);
      ay = coord_value(r.ay);
      bx = coord_value(r.bx);
      by = coord_value(r.by);
      cx = coord_value(r.cx);
      cy = coord_value(r.cy);
      dx = coord_value(r.dx);
      dy = coord_value(r.dy);
      s_c = orientation(ax, ay, bx, by, cx, cy);
      s_d = orientation(ax, ay, bx, by, dx, dy);
      s_a = orientation(cx, cy, dx, dy, ax, ay);
      s_b = orientation(cx, cy, dx, dy, bx, by);
      touch = (s_c == 0 && in_span(ax, bx, cx) && in_span(ay, by, cy)) ||
              (s_d == 0 && in_span(ax, bx, dx) && in_span(ay, by, dy)) ||
              (s_a == 0 && in_span(cx, dx, ax) && in_span(cy, dy, ay)) ||
              (s_b == 0 && in_span(cx, dx, bx) && in_span(cy, dy, by));
      if (touch) return KIND_ENDPOINT;
      if (s_c * s_d < 0 && s_a * s_b < 0) return KIND_CROSSING;
      return KIND_NONE;
   endfunction

   task automatic report(input string msg);
      $display("%0t error: %s", $time, msg);
      errors++;
   endtask

   always @(posedge clock) begin : watch
      kind_type want;
      if (!reset) begin
         if (req_mon.valid && req_mon.ready) begin
            want = classify(req_mon.data);
            expected_kinds.push_back(want);
            case (want)
               KIND_ENDPOINT: n_touch++;
               KIND_CROSSING: n_cross++;
               default:       n_apart++;
            endcase
         end
         if (rsp_mon.valid && rsp_mon.ready) begin
            if (expected_kinds.size() == 0) begin
               report("response transaction with nothing outstanding");
            end else begin
               want = expected_kinds.pop_front();
               if (rsp_mon.data.intersects !== (want != KIND_NONE))
                  report($sformatf("intersects %b, expected %b",
                                   rsp_mon.data.intersects, want != KIND_NONE));
               if (rsp_mon.data.contact_kind !== want)
                  report($sformatf("contact_kind %0d, expected %0d",
                                   rsp_mon.data.contact_kind, want));
            end
         end
      end
   end

endmodule

// File: verif/segment_intersection_test_top_tb.sv
`timescale 1ns / 1ps

module segment_intersection_test_top_tb;
   import sit_pkg::*;

   localparam int RANDOM_PAIRS = 500;
   localparam int CYCLE_LIMIT  = 100000;

   logic clock;
   logic reset;
   bit   no_idle = 1'b0;
   int   cycles = 0;
   int   n_directed = 0;
   int   n_random = 0;
   int   fail_count, pending, seen_apart, seen_touch, seen_cross;

   sit_req_if req_ch ();
   sit_rsp_if rsp_ch ();

   segment_intersection_test_top u_dut (
      .clock (clock),
      .reset (reset),
      .req   (req_ch),
      .rsp   (rsp_ch)
   );

   segment_intersection_checker u_check (
      .clock      (clock),
      .reset      (reset),
      .req_mon    (req_ch),
      .rsp_mon    (rsp_ch),
      .fail_count (fail_count),
      .pending    (pending),
      .seen_apart (seen_apart),
      .seen_touch (seen_touch),
      .seen_cross (seen_cross)
   );

   initial begin
      clock = 1'b0;
      forever #4 clock = ~clock;
   end

   always @(posedge clock) begin
      cycles++;
      if (cycles > CYCLE_LIMIT) begin
         $display("segment_intersection_test_top: mismatch");
         $finish;
      end
   end

   initial begin
      rsp_ch.ready = 1'b0;
      forever begin
         @(negedge clock);
         rsp_ch.ready = no_idle || ($urandom_range(0, 99) >= 20);
      end
   end

   function automatic req_type make_pair(input int ax, input int ay, input int bx,
                                         input int by, input int cx, input int cy,
                                         input int dx, input int dy);
      req_type r;
      r.ax = coord_type'(ax);
      r.ay = coord_type'(ay);
      r.bx = coord_type'(bx);
      r.by = coord_type'(by);
      r.cx = coord_type'(cx);
      r.cy = coord_type'(cy);
      r.dx = coord_type'(dx);
      r.dy = coord_type'(dy);
      return r;
   endfunction

   function automatic int extreme_coord();
      int pick;
      pick = $urandom_range(0, 6);
      case (pick)
         0:       return -32768;
         1:       return -32767;
         2:       return -1;
         3:       return 0;
         4:       return 1;
         5:       return 32766;
         default: return 32767;
      endcase
   endfunction

   function automatic int near(input int span);
      return $urandom_range(0, 2 * span) - span;
   endfunction

   function automatic req_type random_pair();
      req_type r;
      int      shape;
      int      ax, ay, ux, uy, k;
      shape = $urandom_range(0, 9);
      ax = near(1000);
      ay = near(1000);
      ux = near(100);
      uy = near(100);
      case (shape)
         0, 1, 2: begin
            r = req_type'({$urandom(), $urandom(), $urandom(), $urandom()});
         end
         3, 4: begin
            r = make_pair(near(4), near(4), near(4), near(4),
                          near(4), near(4), near(4), near(4));
         end
         5: begin
            // endpoint of CD placed on AB: at A, at B or at the midpoint; maybe swapped
            k = $urandom_range(0, 2);
            r = make_pair(ax, ay, ax + 2 * ux, ay + 2 * uy,
                          ax + k * ux, ay + k * uy, near(1000), near(1000));
            if ($urandom_range(0, 1))
               r = make_pair(r.cx, r.cy, r.dx, r.dy, r.ax, r.ay, r.bx, r.by);
         end
         6: begin
            r = make_pair(ax, ay,
                          ax + near(3) * ux, ay + near(3) * uy,
                          ax + near(3) * ux, ay + near(3) * uy,
                          ax + near(3) * ux, ay + near(3) * uy);
         end
         7: begin
            r = make_pair(near(4), near(4), 0, 0, near(4), near(4), near(4), near(4));
            r.bx = r.ax;
            r.by = r.ay;
            k = $urandom_range(0, 3);
            if (k == 0) begin
               r.cx = r.ax;
               r.cy = r.ay;
            end else if (k == 1) begin
               r.dx = r.cx;
               r.dy = r.cy;
            end
         end
         8: begin
            r = make_pair(extreme_coord(), extreme_coord(), extreme_coord(),
                          extreme_coord(), extreme_coord(), extreme_coord(),
                          extreme_coord(), extreme_coord());
         end
         default: begin
            r = make_pair(near(50), near(50), near(50), near(50),
                          near(50), near(50), near(50), near(50));
         end
      endcase
      return r;
   endfunction

   // entered and left at a falling edge; valid stays high between back-to-back pairs
   task automatic send_pair(input req_type item);
      while (!no_idle && $urandom_range(0, 99) < 20) begin
         req_ch.valid = 1'b0;
         @(negedge clock);
      end
      req_ch.valid = 1'b1;
      req_ch.data  = item;
      forever begin
         @(posedge clock);
         if (req_ch.ready) break;
      end
      @(negedge clock);
   endtask

   initial begin
      req_type directed[$];
      reset        = 1'b1;
      req_ch.valid = 1'b0;
      req_ch.data  = '0;

      directed.push_back(make_pair(-32768, -32768, -32768, -32768,
                                   -32768, -32768, -32768, -32768));
      directed.push_back(make_pair(32767, 32767, 32767, 32767,
                                   32767, 32767, 32767, 32767));
      directed.push_back(make_pair(-32768, -32768, 32767, 32767,
                                   -32768, 32767, 32767, -32768));
      directed.push_back(make_pair(32767, 0, -32768, 0, 0, 32767, 0, -32768));
      directed.push_back(make_pair(-32768, -32768, 32767, -32768,
                                   0, -32768, 0, 32767));
      directed.push_back(make_pair(-32768, -32768, 32767, 32767,
                                   -32767, -32768, 32767, 32766));
      directed.push_back(make_pair(0, 0, 10, 0, 5, 0, 5, 5));
      directed.push_back(make_pair(0, 0, 4, 4, 4, 4, 8, 0));
      directed.push_back(make_pair(0, 0, 6, 0, 3, 0, 9, 0));
      directed.push_back(make_pair(0, 0, 2, 0, 3, 0, 5, 0));
      directed.push_back(make_pair(0, 0, 2, 2, 3, 3, 4, 0));
      directed.push_back(make_pair(3, 3, 3, 3, 3, 3, 7, 1));
      directed.push_back(make_pair(1, 1, 1, 1, 0, 0, 4, 0));
      directed.push_back(make_pair(2, 0, 2, 0, 0, 0, 4, 0));
      directed.push_back(make_pair(5, 5, 5, 5, 5, 5, 5, 5));
      directed.push_back(make_pair(5, 5, 5, 5, 6, 6, 6, 6));
      directed.push_back(make_pair(0, 0, 4, 0, 0, 1, 4, 1));
      directed.push_back(make_pair(0, 0, 1, 1, 3, 0, 2, 1));
      directed.push_back(make_pair(0, 0, 4, 0, 1, 1, 3, 2));
      directed.push_back(make_pair(-1, -1, 1, 1, -1, 1, 1, -1));
      directed.push_back(make_pair('h5555, 'hAAAA, 'hAAAA, 'h5555,
                                   'h5555, 'h5555, 'hAAAA, 'hAAAA));
      directed.push_back(make_pair('hAAAA, 'h5555, 'h5555, 'hAAAA,
                                   'hAAAA, 'hAAAA, 'h5555, 'h5555));

      repeat (5) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      foreach (directed[i]) begin
         send_pair(directed[i]);
         n_directed++;
      end
      for (int i = 0; i < RANDOM_PAIRS; i++) begin
         no_idle = (i >= 200 && i < 320);
         send_pair(random_pair());
         n_random++;
      end
      req_ch.valid = 1'b0;
      no_idle      = 1'b0;

      while (pending != 0) @(posedge clock);
      repeat (2 * STAGES + 4) @(posedge clock);

      $display("covered %0d directed and %0d random segment pairs", n_directed, n_random);
      $display("outcomes: %0d apart, %0d touching, %0d crossing",
               seen_apart, seen_touch, seen_cross);
      if (fail_count == 0) begin
         $display("segment_intersection_test_top: match");
      end else begin
         $display("segment_intersection_test_top: mismatch");
      end
      $finish;
   end

endmodule
